// File: rtl/core/gda_pkg.sv
// ============================================================================
// gda_pkg
// Types, constants and the month-length function for the Gregorian date adder.
// ============================================================================
package gda_pkg;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int ADD_W   = 15;
	// Running day count: start day + a full year + the largest count fits in 16 bits.
	localparam int REM_W   = 16;

	localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
	localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
	localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

	// Leap rule constants (years taken modulo the 400-year cycle).
	localparam logic [YEAR_W-1:0] YEAR_CYCLE  = 14'd400;
	localparam logic [YEAR_W-1:0] CENTURY_1   = 14'd100;
	localparam logic [YEAR_W-1:0] CENTURY_2   = 14'd200;
	localparam logic [YEAR_W-1:0] CENTURY_3   = 14'd300;
	localparam logic [YEAR_W-1:0] CYCLE_LAST  = 14'd399;
	localparam logic [YEAR_W-1:0] YEAR_MAX    = 14'h3FFF;

	localparam logic [DAY_W-1:0] FEB_LEAP_LEN = 5'd29;

	localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef struct packed {
		logic [DAY_W-1:0]   start_day;
		logic [MONTH_W-1:0] start_month;
		logic [YEAR_W-1:0]  start_year;
		logic [ADD_W-1:0]   days_to_add;
	} in_item_t;

	typedef struct packed {
		logic [DAY_W-1:0]   end_day;
		logic [MONTH_W-1:0] end_month;
		logic [YEAR_W-1:0]  end_year;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_SUM,
		S_WALK,
		S_DONE
	} state_t;

	// Length of a month; months outside January..December have no days.
	function automatic logic [DAY_W-1:0] month_length(
		input logic [MONTH_W-1:0] m,
		input logic               leap
	);
		logic [DAY_W-1:0] len;
		len = '0;
		if (m == FEBRUARY) begin
			len = leap ? FEB_LEAP_LEN : MONTH_LEN[1];
		end else if (m >= JANUARY && m <= DECEMBER) begin
			len = MONTH_LEN[m - JANUARY];
		end
		return len;
	endfunction

endpackage

// File: rtl/core/gda_if.sv
// ============================================================================
// gda_if
// Valid/ready channels carrying date items into and out of the adder.
// ============================================================================
interface gda_in_if import gda_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface gda_out_if import gda_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/gregorian_date_add_days_top.sv
// ============================================================================
// gregorian_date_add_days_top
// Adds a day count to a Gregorian date with a month-by-month walk.
// ============================================================================
// Each accepted item runs through S_MOD (year modulo 400), S_SUM (the months
// before the start month) and S_WALK (the month walk) to S_DONE.
// Throughput: one item at a time; the month walk through one shared
// add/subtract unit sets the rate. The next item is taken once the result left.
// Reset: arst_n clears the sequencer to idle at once; no clearing pass.

module gregorian_date_add_days_top import gda_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	gda_in_if.sink    req,
	gda_out_if.source res
);

	state_t state_q, state_d;

	// Working registers. rem_q holds the running day count, ymod_q the year
	// modulo 400 (first as a remainder being reduced, then tracked with the year).
	logic [REM_W-1:0]   rem_q;
	logic [MONTH_W-1:0] month_q;
	logic [MONTH_W-1:0] start_month_q;
	logic [MONTH_W-1:0] cnt_q;
	logic [YEAR_W-1:0]  year_q;
	logic [YEAR_W-1:0]  ymod_q;

	logic               leap;
	logic [MONTH_W-1:0] len_month;
	logic [DAY_W-1:0]   len;
	logic [REM_W-1:0]   len_ext;
	logic               alu_sub;
	logic [REM_W-1:0]   alu_out;
	logic               walk_more;
	logic               mod_done;
	logic               sum_done;

	// Leap test on the year within its 400-year cycle. Since 400 is a
	// multiple of four, the low two bits still give divisibility by four.
	assign leap = (ymod_q == '0) ||
		((ymod_q[1:0] == 2'b00) && (ymod_q != CENTURY_1) &&
		 (ymod_q != CENTURY_2) && (ymod_q != CENTURY_3));

	// The shared unit: one month-length lookup feeding one adder/subtractor.
	// While summing the months before the start month it adds; during the
	// walk it subtracts the current month's length.
	assign len_month = (state_q == S_SUM) ? cnt_q : month_q;
	assign len       = month_length(len_month, leap);
	assign len_ext   = REM_W'(len);
	assign alu_sub   = (state_q == S_WALK);
	assign alu_out   = alu_sub ? (rem_q - len_ext) : (rem_q + len_ext);

	assign walk_more = (rem_q > len_ext);
	assign mod_done  = (ymod_q < YEAR_CYCLE);
	assign sum_done  = (cnt_q >= start_month_q);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) state_d = S_MOD;
			end
			S_MOD: begin
				if (mod_done) state_d = S_SUM;
			end
			S_SUM: begin
				if (sum_done) state_d = S_WALK;
			end
			S_WALK: begin
				if (!walk_more) state_d = S_DONE;
			end
			S_DONE: begin
				if (res.ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Handshake outputs. The result registers hold still through S_DONE.
	always_comb begin
		req.ready = (state_q == S_IDLE);
		res.valid = (state_q == S_DONE);
		res.payload.end_day   = rem_q[DAY_W-1:0];
		res.payload.end_month = month_q;
		res.payload.end_year  = year_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					// Day and count are summed up front; only the months remain.
					rem_q         <= REM_W'(req.payload.start_day) +
						REM_W'(req.payload.days_to_add);
					start_month_q <= req.payload.start_month;
					year_q        <= req.payload.start_year;
					ymod_q        <= req.payload.start_year;
					cnt_q         <= JANUARY;
					month_q       <= JANUARY;
				end
			end
			S_MOD: begin
				// Reduce the year modulo 400 by repeated subtraction.
				if (!mod_done) ymod_q <= ymod_q - YEAR_CYCLE;
			end
			S_SUM: begin
				if (!sum_done) begin
					rem_q <= alu_out;
					cnt_q <= cnt_q + 4'd1;
				end
			end
			S_WALK: begin
				if (walk_more) begin
					rem_q <= alu_out;
					if (month_q == DECEMBER) begin
						month_q <= JANUARY;
						year_q  <= year_q + 14'd1;
						// The 14-bit year wraps to zero, which starts a new cycle.
						if (year_q == YEAR_MAX || ymod_q == CYCLE_LAST) begin
							ymod_q <= '0;
						end else begin
							ymod_q <= ymod_q + 14'd1;
						end
					end else begin
						month_q <= month_q + 4'd1;
					end
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// File: tb/sv/gregorian_date_add_days_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// gregorian_date_add_days_top_tb
// Self-checking bench for the date adder. A table of directed dates comes
// first, then random dates. Each accepted item has its expected date queued here,
// and every result is compared field by field against the oldest prediction.
// ============================================================================
module gregorian_date_add_days_top_tb;
	import gda_pkg::*;

	localparam int N_DIRECTED   = 23;
	localparam int RANDOM_ITEMS = 520;
	// The limit covers every item at the adder's worst case, with stalls, several
	// times over.
	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int DRAIN_CYCLES = 1200;
	localparam int LONG_HOLD    = 3000;

	localparam int unsigned DAYS_PER_MONTH [12] = '{
		31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
	};

	typedef enum int {
		SINK_ALWAYS,
		SINK_HALF,
		SINK_SPARSE,
		SINK_PERIODIC
	} sink_mode_t;

	typedef struct {
		in_item_t  item;
		bit        known;
		out_item_t date;
	} date_case_t;

	logic clk;
	logic arst_n;

	gda_in_if  req_ch ();
	gda_out_if res_ch ();

	gregorian_date_add_days_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	out_item_t pending_dates [$];
	out_item_t want_date;
	bit        mismatch;
	int        accepted_items;
	int        burst_left;
	int unsigned cycle_count;

	// Directed dates. A result is typed in only where it follows at a glance;
	// the rest rely on the predictor.
	date_case_t directed_cases [N_DIRECTED] = '{
		// Smallest real date, nothing added.
		'{'{5'd1, JANUARY, 14'd1, 15'd0}, 1'b1, '{5'd1, JANUARY, 14'd1}},
		// Last day of the largest listed year rolls into the next year.
		'{'{5'd31, DECEMBER, 14'd9999, 15'd1}, 1'b1, '{5'd1, JANUARY, 14'd10000}},
		// Divisible by 400: leap.
		'{'{5'd28, FEBRUARY, 14'd2000, 15'd1}, 1'b1, '{5'd29, FEBRUARY, 14'd2000}},
		// Divisible by 100 only: not leap.
		'{'{5'd28, FEBRUARY, 14'd1900, 15'd1}, 1'b1, '{5'd1, 4'd3, 14'd1900}},
		// Divisible by 4: leap.
		'{'{5'd28, FEBRUARY, 14'd2024, 15'd1}, 1'b1, '{5'd29, FEBRUARY, 14'd2024}},
		// Start day zero in January with nothing added gives day zero.
		'{'{5'd0, JANUARY, 14'd5, 15'd0}, 1'b1, '{5'd0, JANUARY, 14'd5}},
		// Month zero: the day of the year is just the start day.
		'{'{5'd5, 4'd0, 14'd2001, 15'd10}, 1'b1, '{5'd15, JANUARY, 14'd2001}},
		// Month thirteen counts a whole year before the start day.
		'{'{5'd10, 4'd13, 14'd2001, 15'd0}, 1'b1, '{5'd10, JANUARY, 14'd2002}},
		// Day past the end of its month rolls forward.
		'{'{5'd31, FEBRUARY, 14'd2001, 15'd0}, 1'b1, '{5'd3, 4'd3, 14'd2001}},
		// Year wraps from the top of the register to zero.
		'{'{5'd31, DECEMBER, 14'd16383, 15'd1}, 1'b1, '{5'd1, JANUARY, 14'd0}},
		// Year zero is a leap year.
		'{'{5'd1, JANUARY, 14'd0, 15'd59}, 1'b1, '{5'd29, FEBRUARY, 14'd0}},
		// All fields zero.
		'{'{5'd0, 4'd0, 14'd0, 15'd0}, 1'b1, '{5'd0, JANUARY, 14'd0}},
		// Largest day and month in the last year wrap into year zero.
		'{'{5'd31, 4'd15, 14'd16383, 15'd0}, 1'b1, '{5'd31, JANUARY, 14'd0}},
		// Century year that is not leap, first of March.
		'{'{5'd1, 4'd3, 14'd2100, 15'd0}, 1'b1, '{5'd1, 4'd3, 14'd2100}},
		// Last day of a common year stays put.
		'{'{5'd31, DECEMBER, 14'd2023, 15'd0}, 1'b1, '{5'd31, DECEMBER, 14'd2023}},
		// Month fifteen in leap year zero lands on the last day of that year.
		'{'{5'd0, 4'd15, 14'd0, 15'd0}, 1'b1, '{5'd31, DECEMBER, 14'd0}},
		'{'{5'd1, JANUARY, 14'd1, 15'd32767}, 1'b0, '0},
		'{'{5'd31, 4'd15, 14'd16383, 15'd32767}, 1'b0, '0},
		'{'{5'd31, DECEMBER, 14'd16383, 15'd32767}, 1'b0, '0},
		'{'{5'd29, FEBRUARY, 14'd2000, 15'd365}, 1'b0, '0},
		'{'{5'd15, 4'd6, 14'd2023, 15'd200}, 1'b0, '0},
		'{'{5'd30, 4'd11, 14'd2399, 15'd33}, 1'b0, '0},
		'{'{5'd31, JANUARY, 14'd1, 15'd31}, 1'b0, '0}
	};

	always #10 clk = ~clk;

	// Gregorian rule: every fourth year, except centuries not divisible by 400.
	function automatic bit leap_year(input logic [YEAR_W-1:0] yr);
		int unsigned y;
		y = yr;
		return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
	endfunction

	function automatic int unsigned days_in_month(input int unsigned month_no,
			input logic [YEAR_W-1:0] yr);
		if (month_no < 1 || month_no > 12) begin
			return 0;
		end
		if (month_no == 2) begin
			return leap_year(yr) ? 29 : 28;
		end
		return DAYS_PER_MONTH[month_no - 1];
	endfunction

	// Day of the year plus the count, then a walk from January that peels off
	// whole months and rolls the 14-bit year past December.
	function automatic out_item_t expected_date(input in_item_t it);
		out_item_t        r;
		int unsigned      left;
		int unsigned      mon;
		logic [YEAR_W-1:0] yr;
		yr   = it.start_year;
		left = it.start_day;
		for (mon = 1; mon < it.start_month; mon++) begin
			left += days_in_month(mon, yr);
		end
		left += it.days_to_add;
		mon = 1;
		while (left > days_in_month(mon, yr)) begin
			left -= days_in_month(mon, yr);
			mon++;
			if (mon > 12) begin
				mon = 1;
				yr  = yr + 1'b1;
			end
		end
		r.end_day   = DAY_W'(left);
		r.end_month = MONTH_W'(mon);
		r.end_year  = yr;
		return r;
	endfunction

	// Mostly real dates with short counts, so that runs stay short; some
	// dates use any bit pattern, some sit near the year wrap, and a few
	// counts span the whole range.
	function automatic in_item_t random_date_item();
		in_item_t    it;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 70) begin
			it.start_month = $urandom_range(12, 1);
			it.start_year  = $urandom_range(9999, 1);
			it.start_day   = $urandom_range(days_in_month(it.start_month, it.start_year), 1);
		end else if (pick < 80) begin
			it.start_month = $urandom_range(15, 0);
			it.start_year  = $urandom_range(16383, 16300);
			it.start_day   = $urandom_range(31, 1);
		end else begin
			it.start_month = $urandom_range(15, 0);
			it.start_year  = $urandom_range(16383, 0);
			it.start_day   = $urandom_range(31, 0);
		end
		pick = $urandom_range(99);
		if (pick < 75) begin
			it.days_to_add = $urandom_range(400, 0);
		end else if (pick < 90) begin
			it.days_to_add = $urandom_range(4000, 0);
		end else begin
			it.days_to_add = $urandom_range(32767, 0);
		end
		return it;
	endfunction

	// Offers one item in bursts; between bursts the request line drops for a
	// random gap. The prediction is queued at the edge that takes the item.
	task automatic send_date(input in_item_t item, input bit known, input out_item_t date);
		if (burst_left == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(20, 1)) @(posedge clk);
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 10)
				: $urandom_range(8, 1);
		end
		burst_left--;
		req_ch.valid   <= 1'b1;
		req_ch.payload <= item;
		do @(posedge clk); while (!req_ch.ready);
		pending_dates.push_back(known ? date : expected_date(item));
		accepted_items++;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatch = 1'b1;
		end
	endtask

	// Stimulus: reset, the directed table, then random dates, then drain.
	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.payload = '0;
		mismatch       = 1'b0;
		accepted_items = 0;
		burst_left     = $urandom_range(8, 1);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_DIRECTED; i++) begin
			send_date(directed_cases[i].item, directed_cases[i].known,
				directed_cases[i].date);
		end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			send_date(random_date_item(), 1'b0, '0);
		end
		req_ch.valid <= 1'b0;
		while (pending_dates.size() != 0) @(posedge clk);
		// Any stray result would still show up within the adder's worst-case latency.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!mismatch) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Receiver: picks a new stall pattern for each random window, and once,
	// after the directed part, holds off long enough for the adder to finish
	// its item and refuse the next one.
	initial begin
		sink_mode_t sink_mode;
		int         window_left;
		int         hold_left;
		bit         hold_done;
		bit         take;
		int unsigned phase;
		res_ch.ready = 1'b0;
		window_left  = 0;
		hold_left    = 0;
		hold_done    = 1'b0;
		phase        = 0;
		sink_mode    = SINK_ALWAYS;
		forever begin
			@(posedge clk);
			phase++;
			if (hold_left != 0) begin
				hold_left--;
			end else if (!hold_done && accepted_items >= N_DIRECTED + 40) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (window_left == 0) begin
				sink_mode   = sink_mode_t'($urandom_range(3));
				window_left = $urandom_range(80, 20);
			end
			window_left--;
			case (sink_mode)
				SINK_ALWAYS:   take = 1'b1;
				SINK_HALF:     take = $urandom_range(1);
				SINK_SPARSE:   take = ($urandom_range(3) == 0);
				default:       take = (phase % 8) < 3;
			endcase
			res_ch.ready <= take && hold_left == 0;
		end
	end

	// Result check against the oldest prediction.
	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready) begin
			if (pending_dates.size() == 0) begin
				$display("%0t: result %0d/%0d/%0d with no item outstanding", $time,
					res_ch.payload.end_day, res_ch.payload.end_month,
					res_ch.payload.end_year);
				mismatch = 1'b1;
			end else begin
				want_date = pending_dates.pop_front();
				check_field("end_day", want_date.end_day, res_ch.payload.end_day);
				check_field("end_month", want_date.end_month, res_ch.payload.end_month);
				check_field("end_year", want_date.end_year, res_ch.payload.end_year);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_dates.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial cycle_count = 0;

endmodule

// File: filelist.f
rtl/core/gda_pkg.sv
rtl/core/gda_if.sv
rtl/core/gregorian_date_add_days_top.sv
tb/sv/gregorian_date_add_days_top_tb.sv
